FILE: sv/srm_pkg.sv
// Shared types and constants for the step response monitor.
// Used by every module of the block; depends on nothing.
`default_nettype none
package srm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 32;
  localparam int ADDR_WIDTH   = 3;
  localparam int DATA_WIDTH   = 32;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [SAMPLE_WIDTH-1:0] band_t;
  typedef logic        [COUNT_WIDTH-1:0]  count_t;
  typedef logic        [ADDR_WIDTH-1:0]   addr_t;
  typedef logic        [DATA_WIDTH-1:0]   data_t;

  localparam band_t SETTLE_BAND_RESET = band_t'(48);

  typedef enum logic {
    REG_SETPOINT    = 1'b0,
    REG_SETTLE_BAND = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_e;

  typedef struct packed {
    sample_t setpoint;
    band_t   settle_band;
  } cfg_t;

  typedef struct packed {
    band_t  overshoot_up;
    band_t  overshoot_down;
    count_t reversal_total;
    count_t settle_sample;
    logic   above_seen;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/srm_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on srm_pkg.
`default_nettype none
module srm_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire srm_pkg::addr_t paddr,
  input  wire srm_pkg::data_t pwdata,
  output srm_pkg::data_t     prdata,
  output logic               pready,
  output srm_pkg::cfg_t      cfg_o
);
  import srm_pkg::*;

  sample_t  setpoint_q;
  band_t    settle_band_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      settle_band_q <= SETTLE_BAND_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SETPOINT:    setpoint_q    <= sample_t'(pwdata[SAMPLE_WIDTH-1:0]);
        REG_SETTLE_BAND: settle_band_q <= pwdata[SAMPLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETPOINT:    prdata = {{(DATA_WIDTH-SAMPLE_WIDTH){1'b0}}, setpoint_q};
      REG_SETTLE_BAND: prdata = {{(DATA_WIDTH-SAMPLE_WIDTH){1'b0}}, settle_band_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.setpoint    = setpoint_q;
  assign cfg_o.settle_band = settle_band_q;

endmodule
`default_nettype wire

FILE: sv/srm_track.sv
// Trend, reversal, settling and overshoot tracking; its state registers
// double as the result register. Depends on srm_pkg.
`default_nettype none
module srm_track (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire srm_pkg::sample_t temp_i,
  input  wire srm_pkg::cfg_t  cfg_i,
  output srm_pkg::res_t       res_o
);
  import srm_pkg::*;

  sample_t last_sample_q, reversal_ref_q, first_high_q, running_max_q, running_min_q;
  sample_t reversal_ref_d, first_high_d, running_max_d, running_min_d;
  trend_e  last_trend_q, trend;
  count_t  reversal_count_q, reversal_count_d;
  count_t  sample_index_q, sample_index_d;
  count_t  settle_index_q, settle_index_d;
  band_t   up_delta_q, up_delta_d, down_delta_q, down_delta_d;
  logic    armed_q, armed_d;
  logic    reversal;
  logic signed [SAMPLE_WIDTH:0] diff;
  logic        [SAMPLE_WIDTH:0] mag;

  always_comb begin
    trend          = (last_sample_q <= temp_i) ? TREND_UP : TREND_DOWN;
    sample_index_d = sample_index_q + 1'b1;
    reversal       = (last_trend_q != TREND_NONE) && (last_trend_q != trend);
    diff = $signed({reversal_ref_q[SAMPLE_WIDTH-1], reversal_ref_q})
         - $signed({temp_i[SAMPLE_WIDTH-1], temp_i});
    mag  = diff[SAMPLE_WIDTH] ? -diff : diff;

    reversal_count_d = reversal_count_q;
    settle_index_d   = settle_index_q;
    reversal_ref_d   = reversal_ref_q;
    if (reversal) begin
      reversal_count_d = reversal_count_q + 1'b1;
      if (settle_index_q == '0) begin
        if (mag < {1'b0, cfg_i.settle_band}) begin
          settle_index_d = sample_index_d;
        end else begin
          reversal_ref_d = temp_i;
        end
      end
    end

    armed_d       = armed_q;
    first_high_d  = first_high_q;
    running_max_d = running_max_q;
    running_min_d = running_min_q;
    up_delta_d    = up_delta_q;
    down_delta_d  = down_delta_q;
    if (!armed_q) begin
      if (temp_i > cfg_i.setpoint) begin
        armed_d       = 1'b1;
        first_high_d  = temp_i;
        running_max_d = temp_i;
        running_min_d = temp_i;
      end
    end else begin
      if (temp_i > running_max_q) begin
        running_max_d = temp_i;
        up_delta_d    = band_t'(temp_i - first_high_q);
      end
      if (temp_i < running_min_q) begin
        running_min_d = temp_i;
        down_delta_d  = band_t'(first_high_q - temp_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q    <= '0;
      last_trend_q     <= TREND_NONE;
      reversal_ref_q   <= '0;
      reversal_count_q <= '0;
      sample_index_q   <= '0;
      settle_index_q   <= '0;
      armed_q          <= 1'b0;
      first_high_q     <= '0;
      running_max_q    <= '0;
      running_min_q    <= '0;
      up_delta_q       <= '0;
      down_delta_q     <= '0;
    end else if (load_i) begin
      last_sample_q    <= temp_i;
      last_trend_q     <= trend;
      reversal_ref_q   <= reversal_ref_d;
      reversal_count_q <= reversal_count_d;
      sample_index_q   <= sample_index_d;
      settle_index_q   <= settle_index_d;
      armed_q          <= armed_d;
      first_high_q     <= first_high_d;
      running_max_q    <= running_max_d;
      running_min_q    <= running_min_d;
      up_delta_q       <= up_delta_d;
      down_delta_q     <= down_delta_d;
    end
  end

  assign res_o.overshoot_up   = up_delta_q;
  assign res_o.overshoot_down = down_delta_q;
  assign res_o.reversal_total = reversal_count_q;
  assign res_o.settle_sample  = settle_index_q;
  assign res_o.above_seen     = armed_q;

endmodule
`default_nettype wire

FILE: sv/step_response_monitor.sv
// Step response monitor: one result per temperature request.
// An accepted request goes into the input register, then into the tracking state.
// Throughput: one request per cycle while out_stall_i is low; the input register
// and the tracking state (which is also the result register) advance together.
// Reset: asynchronous, active low; clears all tracking state, setpoint to 0,
// settle band to 48. Depends on srm_pkg, srm_cfg, srm_track.
`default_nettype none
module step_response_monitor (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire srm_pkg::addr_t   paddr,
  input  wire srm_pkg::data_t   pwdata,
  output srm_pkg::data_t        prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire srm_pkg::sample_t temperature_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output srm_pkg::band_t        overshoot_up_o,
  output srm_pkg::band_t        overshoot_down_o,
  output srm_pkg::count_t       reversal_total_o,
  output srm_pkg::count_t       settle_sample_o,
  output logic                  above_seen_o
);
  import srm_pkg::*;

  cfg_t    cfg;
  res_t    res;
  logic    in_valid_q, out_valid_q;
  sample_t temp_q;
  logic    advance, in_take, out_take;

  srm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_take   = out_valid_q && !out_stall_i;
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      temp_q <= temperature_i;
    end
  end

  srm_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .temp_i (temp_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o      = out_valid_q;
  assign overshoot_up_o   = res.overshoot_up;
  assign overshoot_down_o = res.overshoot_down;
  assign reversal_total_o = res.reversal_total;
  assign settle_sample_o  = res.settle_sample;
  assign above_seen_o     = res.above_seen;

endmodule
`default_nettype wire

FILE: sv/srm_checker.sv
// Port-level checks for the step response monitor, bound to the top level.
// Depends on srm_pkg and step_response_monitor.
`default_nettype none
module srm_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire srm_pkg::band_t   overshoot_up_o,
  input wire srm_pkg::band_t   overshoot_down_o,
  input wire srm_pkg::count_t  reversal_total_o,
  input wire srm_pkg::count_t  settle_sample_o,
  input wire logic             above_seen_o
);
  import srm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reversal_total_o))
    else $error("stalled result dropped or changed");

  a_above_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(above_seen_o))
    else $error("above_seen cleared");

  a_settle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(settle_sample_o) != '0 |-> $stable(settle_sample_o))
    else $error("settle index changed after settling");

  a_rev_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(reversal_total_o) |-> reversal_total_o == $past(reversal_total_o) + 1'b1)
    else $error("reversal count jumped");

  a_no_overshoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !above_seen_o |-> overshoot_up_o == '0 && overshoot_down_o == '0)
    else $error("overshoot before setpoint crossed");

endmodule

bind step_response_monitor srm_checker u_srm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .overshoot_up_o   (overshoot_up_o),
  .overshoot_down_o (overshoot_down_o),
  .reversal_total_o (reversal_total_o),
  .settle_sample_o  (settle_sample_o),
  .above_seen_o     (above_seen_o)
);
`default_nettype wire
